// File: rtl/dpc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and control types for the deadline pacer.
package dpc_pkg;

  localparam int WORD_W     = 64;
  localparam int DIGIT_W    = 8;
  localparam int NUM_DIGITS = WORD_W / DIGIT_W;
  localparam int STEP_W     = $clog2(NUM_DIGITS);
  localparam int OUT_W      = 32;
  localparam int LOW_DIGITS = OUT_W / DIGIT_W;
  localparam int NOW_W      = 63;
  localparam int FUNC_W     = 2;

  localparam int DEF_MAX_CATCH_UP = 4;

  localparam logic [OUT_W-1:0] DEFAULT_INTERVAL_NS = 32'd16000000;
  localparam logic [OUT_W-1:0] MIN_INTERVAL_NS     = 32'd1000000;

  typedef enum logic [FUNC_W-1:0] {
    OP_WAIT   = 2'd0,
    OP_RESET  = 2'd1,
    OP_STOP   = 2'd2,
    OP_RETIME = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic idle;
    logic busy;
    logic step0;
    logic last;
    logic low_dig;
    logic first_pass;
    logic fin_go;
  } ctl_t;

endpackage

// File: rtl/dpc_digit_add.sv
`timescale 1ns / 1ps
// One digit-serial add or subtract lane with its carry flop.
module dpc_digit_add (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        step0,
  input  logic                        sub,
  input  logic [dpc_pkg::DIGIT_W-1:0] a,
  input  logic [dpc_pkg::DIGIT_W-1:0] b,
  output logic [dpc_pkg::DIGIT_W-1:0] s,
  output logic                        c_o
);
  import dpc_pkg::*;

  logic               carry_r;
  logic               cin;
  logic [DIGIT_W-1:0] b_eff;
  logic [DIGIT_W:0]   sum;

  assign cin   = step0 ? sub : carry_r;
  assign b_eff = sub ? ~b : b;
  assign sum   = {1'b0, a} + {1'b0, b_eff} + {{DIGIT_W{1'b0}}, cin};
  assign s     = sum[DIGIT_W-1:0];
  assign c_o   = sum[DIGIT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      carry_r <= c_o;
    end
  end

endmodule

// File: rtl/dpc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: digit steps, catch-up pass count and result hand-off.
module dpc_ctrl #(
  parameter int MAX_CATCH_UP = dpc_pkg::DEF_MAX_CATCH_UP
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          go_pass,
  input  logic          is_wait,
  input  logic          lt_now,
  input  logic          le_now,
  input  logic          out_free,
  output dpc_pkg::ctl_t ctl
);
  import dpc_pkg::*;

  localparam int CNT_W = (MAX_CATCH_UP > 0) ? $clog2(MAX_CATCH_UP + 1) : 1;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic                first_r, first_nxt;
  logic                wait_r, wait_nxt;
  logic                last_step;

  assign last_step = (step_r == STEP_W'(NUM_DIGITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      k_r     <= '0;
      first_r <= 1'b0;
      wait_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      k_r     <= k_nxt;
      first_r <= first_nxt;
      wait_r  <= wait_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    k_nxt     = k_r;
    first_nxt = first_r;
    wait_nxt  = wait_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          wait_nxt  = is_wait;
          step_nxt  = '0;
          k_nxt     = '0;
          first_nxt = 1'b1;
          state_nxt = go_pass ? ST_PASS : ST_FIN;
        end
      end
      ST_PASS: begin
        if (last_step) begin
          step_nxt  = '0;
          first_nxt = 1'b0;
          if (first_r && (!wait_r || lt_now)) begin
            state_nxt = ST_FIN;
          end else if (le_now && (k_r < CNT_W'(MAX_CATCH_UP))) begin
            k_nxt = k_r + 1'b1;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl            = '0;
    ctl.idle       = (state_r == ST_IDLE);
    ctl.busy       = (state_r == ST_PASS);
    ctl.step0      = (step_r == '0);
    ctl.last       = last_step;
    ctl.low_dig    = (step_r < STEP_W'(LOW_DIGITS));
    ctl.first_pass = first_r;
    ctl.fin_go     = (state_r == ST_FIN) && out_free;
  end

endmodule

// File: rtl/deadline_pacer_catch_up.sv
`timescale 1ns / 1ps
// Top level of the fixed-interval deadline pacer with bounded catch-up.
//
// Input channel in_*: one word per call, an operation (wait, reset, stop,
// retime) and a 63-bit timestamp in ns. Output channel out_*: exactly one
// word per input word, in order. Config channel cfg_*: the frame interval,
// always ready; a written zero stores 1 ms.
// All 64-bit sums and compares run least significant byte first, one byte
// per cycle. Reset, stop and retime while stopped skip the passes: their
// word goes from the finish state straight into the output register. A
// wait that does not fire, and a retime while running, take one pass. A
// firing wait takes 1 + k passes, k being the number of catch-up additions
// (0 to MAX_CATCH_UP).
// One word is in work at a time; the next is taken as soon as the previous
// result sits in the output register. A stalled receiver holds that next
// result in the finish state, and no further word is taken until it moves.
// Reset: pacer stopped, interval 16 ms, output register empty.
module deadline_pacer_catch_up #(
  parameter int MAX_CATCH_UP = dpc_pkg::DEF_MAX_CATCH_UP
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dpc_pkg::FUNC_W-1:0] in_func,
  input  logic [dpc_pkg::NOW_W-1:0]  in_now_ns,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_fired,
  output logic [dpc_pkg::OUT_W-1:0]  out_wait_ns,
  output logic [dpc_pkg::OUT_W-1:0]  out_frame_cost_ns,
  output logic [dpc_pkg::OUT_W-1:0]  out_overshoot_ns,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [dpc_pkg::OUT_W-1:0]  cfg_interval_ns
);
  import dpc_pkg::*;

  ctl_t               ctl;
  logic               in_fire;
  logic               out_free;
  logic               go_pass;
  logic               is_wait;
  logic               rearm;
  op_t                in_op;

  op_t                op_r;
  logic               active_r;
  logic [OUT_W-1:0]   iv_r;
  logic [WORD_W-1:0]  nd_r, lw_r, now_r, ivs_r, acc_r, ni_r;
  logic [OUT_W-1:0]   lo_ov_r, lo_wt_r, lo_cs_r;
  logic               hi_ov_r, hi_wt_r, hi_cs_r;
  logic               lt_r, lwb_r, le_r;

  logic               out_valid_r;
  logic               out_fired_r;
  logic [OUT_W-1:0]   out_wait_r, out_cost_r, out_over_r;

  logic [DIGIT_W-1:0] now_d, nd_d, lw_d, iv_d, acc_a;
  logic [DIGIT_W-1:0] s_ov, s_wt, s_cs, s_acc, s_ni, s_le;
  logic               c_ov, c_wt, c_cs, c_acc, c_ni, c_le;
  logic               fire_res;

  function automatic logic [WORD_W-1:0] rot(input logic [WORD_W-1:0] x);
    rot = {x[DIGIT_W-1:0], x[WORD_W-1:DIGIT_W]};
  endfunction

  function automatic logic [OUT_W-1:0] sat(input logic hi, input logic [OUT_W-1:0] lo);
    sat = hi ? {OUT_W{1'b1}} : lo;
  endfunction

  assign in_op    = op_t'(in_func);
  assign in_ready = ctl.idle;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign is_wait  = (in_op == OP_WAIT);
  assign go_pass  = is_wait || ((in_op == OP_RETIME) && active_r);
  assign rearm    = (in_op == OP_RESET) || (is_wait && !active_r);
  assign cfg_ready = 1'b1;

  assign now_d = now_r[DIGIT_W-1:0];
  assign nd_d  = nd_r[DIGIT_W-1:0];
  assign lw_d  = lw_r[DIGIT_W-1:0];
  assign iv_d  = ivs_r[DIGIT_W-1:0];
  assign acc_a = ctl.first_pass ? nd_d : acc_r[DIGIT_W-1:0];

  dpc_ctrl #(
    .MAX_CATCH_UP(MAX_CATCH_UP)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .go_pass (go_pass),
    .is_wait (is_wait),
    .lt_now  (!c_ov),
    .le_now  (c_le),
    .out_free(out_free),
    .ctl     (ctl)
  );

  // now - deadline
  dpc_digit_add u_ov (.clk(clk), .en(ctl.busy), .step0(ctl.step0), .sub(1'b1),
                      .a(now_d), .b(nd_d), .s(s_ov), .c_o(c_ov));
  // deadline - now
  dpc_digit_add u_wt (.clk(clk), .en(ctl.busy), .step0(ctl.step0), .sub(1'b1),
                      .a(nd_d), .b(now_d), .s(s_wt), .c_o(c_wt));
  // now - last wake
  dpc_digit_add u_cs (.clk(clk), .en(ctl.busy), .step0(ctl.step0), .sub(1'b1),
                      .a(now_d), .b(lw_d), .s(s_cs), .c_o(c_cs));
  // candidate deadline + interval
  dpc_digit_add u_acc (.clk(clk), .en(ctl.busy), .step0(ctl.step0), .sub(1'b0),
                       .a(acc_a), .b(iv_d), .s(s_acc), .c_o(c_acc));
  // now + interval
  dpc_digit_add u_ni (.clk(clk), .en(ctl.busy), .step0(ctl.step0), .sub(1'b0),
                      .a(now_d), .b(iv_d), .s(s_ni), .c_o(c_ni));
  // now - new candidate, no borrow means candidate <= now
  dpc_digit_add u_le (.clk(clk), .en(ctl.busy), .step0(ctl.step0), .sub(1'b1),
                      .a(now_d), .b(s_acc), .s(s_le), .c_o(c_le));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r     <= DEFAULT_INTERVAL_NS;
      active_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        iv_r <= (cfg_interval_ns == '0) ? MIN_INTERVAL_NS : cfg_interval_ns;
      end
      if (in_fire) begin
        case (in_op)
          OP_WAIT:  active_r <= 1'b1;
          OP_RESET: active_r <= 1'b1;
          OP_STOP:  active_r <= 1'b0;
          default:  active_r <= active_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_op;
      now_r <= {1'b0, in_now_ns};
      ivs_r <= {{(WORD_W-OUT_W){1'b0}}, iv_r};
      if (rearm) begin
        nd_r <= {1'b0, in_now_ns};
        lw_r <= {1'b0, in_now_ns};
      end
    end else if (ctl.busy) begin
      now_r <= rot(now_r);
      ivs_r <= rot(ivs_r);
      acc_r <= {s_acc, acc_r[WORD_W-1:DIGIT_W]};
      if (ctl.first_pass) begin
        nd_r <= rot(nd_r);
        lw_r <= rot(lw_r);
        ni_r <= {s_ni, ni_r[WORD_W-1:DIGIT_W]};
        if (ctl.low_dig) begin
          lo_ov_r <= {s_ov, lo_ov_r[OUT_W-1:DIGIT_W]};
          lo_wt_r <= {s_wt, lo_wt_r[OUT_W-1:DIGIT_W]};
          lo_cs_r <= {s_cs, lo_cs_r[OUT_W-1:DIGIT_W]};
        end
        if (ctl.step0) begin
          hi_ov_r <= 1'b0;
          hi_wt_r <= 1'b0;
          hi_cs_r <= 1'b0;
        end else if (!ctl.low_dig) begin
          hi_ov_r <= hi_ov_r | (|s_ov);
          hi_wt_r <= hi_wt_r | (|s_wt);
          hi_cs_r <= hi_cs_r | (|s_cs);
        end
        if (ctl.last) begin
          lt_r  <= !c_ov;
          lwb_r <= !c_cs;
        end
      end
      if (ctl.last) begin
        le_r <= c_le;
      end
    end else if (ctl.fin_go) begin
      if ((op_r == OP_RETIME) && active_r) begin
        nd_r <= ni_r;
      end else if ((op_r == OP_WAIT) && !lt_r) begin
        nd_r <= le_r ? ni_r : acc_r;
        lw_r <= now_r;
      end
    end
  end

  assign fire_res = (op_r == OP_WAIT) && !lt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin_go) begin
      out_fired_r <= fire_res;
      out_wait_r  <= ((op_r == OP_WAIT) && lt_r) ? sat(hi_wt_r, lo_wt_r) : '0;
      out_cost_r  <= (fire_res && !lwb_r) ? sat(hi_cs_r, lo_cs_r) : '0;
      out_over_r  <= fire_res ? sat(hi_ov_r, lo_ov_r) : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fired         = out_fired_r;
  assign out_wait_ns       = out_wait_r;
  assign out_frame_cost_ns = out_cost_r;
  assign out_overshoot_ns  = out_over_r;

`ifndef SYNTHESIS
  a_fired_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fired_r |-> out_wait_r == '0)
    else $error("fired word carries a nonzero wait");

  a_idle_zero_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_fired_r |-> (out_cost_r == '0) && (out_over_r == '0))
    else $error("unfired word carries cost or overshoot");

  a_busy_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.busy |-> !in_ready)
    else $error("input taken during a pass");

  a_wait_leaves_active: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fin_go && (op_r == OP_WAIT) |=> active_r)
    else $error("pacer inactive after a wait");
`endif

endmodule
